>>> rtl/assert_macros.svh
// Assertion macros used by point_segment_distance.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// The expression must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

>>> rtl/psd_pkg.sv
package psd_pkg;

  // Fractional bits of the projection parameter and its value for one.
  localparam int TFrac = 24;
  localparam logic [TFrac:0] TOne = (TFrac + 1)'(1) << TFrac;

  // Root bits produced by the square root, one per stage.
  localparam int SqrtSteps = 32;

  // Difference, product and sum stages, the divider set-up, the divider,
  // the parameter, offset, residual, square and sum stages, the root
  // stages and the output register.
  localparam int Latency = 4 + TFrac + 5 + SqrtSteps + 1;

  localparam logic [30:0] DistMax = 31'h7fff_ffff;

endpackage

>>> rtl/point_segment_distance.sv
// The done strobe is high while the distance of a finished beat is on the output.
// Throughput: one beat per cycle; busy is held low, as every stage advances each cycle.
// The depth comes from the divider (one quotient bit per stage) and the square root
// (one root bit per stage). The receiver cannot stall, so no beat ever waits.
// Reset (rst, synchronous, active high) clears the valid bits; data registers keep junk.
`include "assert_macros.svh"

module point_segment_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] point_x,
  input  logic signed [29:0] point_y,
  input  logic signed [30:0] start_x,
  input  logic signed [29:0] start_y,
  input  logic signed [30:0] end_x,
  input  logic signed [29:0] end_y,
  output logic               done,
  output logic        [30:0] distance
);

  // Stage positions in the valid shift line.
  localparam int DivFirst = 4;
  localparam int TStage   = DivFirst + psd_pkg::TFrac;
  localparam int SumStage = TStage + 4;
  localparam int OutStage = SumStage + psd_pkg::SqrtSteps + 1;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic        [62:0]           r;
    logic        [62:0]           len2;
    logic        [psd_pkg::TFrac-1:0] q;
    logic                         zero;
    logic                         one;
    logic signed [31:0]           ax;
    logic signed [30:0]           ay;
    logic signed [31:0]           dx;
    logic signed [30:0]           dy;
  } div_t;

  // Payload carried through the square root stages.
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] n;
  } sqrt_t;

  // One valid bit per stage; a beat enters whenever start is high.
  logic [psd_pkg::Latency-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[psd_pkg::Latency-2:0], start};
    end
  end

  assign busy = 1'b0;
  assign done = vld[OutStage];

  // Stage one: differences from the segment start. All fit one bit wider
  // than the coordinates.
  logic signed [31:0] s1_ax, s1_dx;
  logic signed [30:0] s1_ay, s1_dy;

  always_ff @(posedge clk) begin
    s1_ax <= 32'(point_x) - 32'(start_x);
    s1_ay <= 31'(point_y) - 31'(start_y);
    s1_dx <= 32'(end_x) - 32'(start_x);
    s1_dy <= 31'(end_y) - 31'(start_y);
  end

  // Stage two: the four products, one multiplier each.
  logic signed [63:0] s2_dxdx, s2_dydy, s2_axdx, s2_aydy;
  logic signed [31:0] s2_ax, s2_dx;
  logic signed [30:0] s2_ay, s2_dy;

  always_ff @(posedge clk) begin
    s2_dxdx <= s1_dx * s1_dx;
    s2_dydy <= s1_dy * s1_dy;
    s2_axdx <= s1_ax * s1_dx;
    s2_aydy <= s1_ay * s1_dy;
    s2_ax   <= s1_ax;
    s2_ay   <= s1_ay;
    s2_dx   <= s1_dx;
    s2_dy   <= s1_dy;
  end

  // Stage three: squared length (below 2^63) and dot product.
  logic        [62:0] s3_len2;
  logic signed [63:0] s3_dot;
  logic signed [31:0] s3_ax, s3_dx;
  logic signed [30:0] s3_ay, s3_dy;

  always_ff @(posedge clk) begin
    s3_len2 <= 63'(s2_dxdx + s2_dydy);
    s3_dot  <= s2_axdx + s2_aydy;
    s3_ax   <= s2_ax;
    s3_ay   <= s2_ay;
    s3_dx   <= s2_dx;
    s3_dy   <= s2_dy;
  end

  // Stage four: the clamp cases are decided here, and the divider starts
  // from the dot product. Its value only matters when it lies strictly
  // between zero and the squared length.
  div_t div_s [psd_pkg::TFrac+1];

  always_ff @(posedge clk) begin
    div_s[0].r    <= s3_dot[62:0];
    div_s[0].len2 <= s3_len2;
    div_s[0].q    <= '0;
    div_s[0].zero <= (s3_len2 == '0) || (s3_dot <= 64'sd0);
    div_s[0].one  <= s3_dot >= $signed({1'b0, s3_len2});
    div_s[0].ax   <= s3_ax;
    div_s[0].ay   <= s3_ay;
    div_s[0].dx   <= s3_dx;
    div_s[0].dy   <= s3_dy;
  end

  // Restoring division, one quotient bit per stage.
  for (genvar g = 0; g < psd_pkg::TFrac; g++) begin : g_div
    logic [63:0] r2;
    logic        ge;
    div_t        div_next;

    assign r2 = {div_s[g].r, 1'b0};
    assign ge = r2 >= {1'b0, div_s[g].len2};

    always_comb begin
      div_next   = div_s[g];
      div_next.r = ge ? 63'(r2 - {1'b0, div_s[g].len2}) : r2[62:0];
      div_next.q = {div_s[g].q[psd_pkg::TFrac-2:0], ge};
    end

    always_ff @(posedge clk) begin
      div_s[g+1] <= div_next;
    end
  end

  // Parameter stage: apply the clamp.
  logic        [psd_pkg::TFrac:0] t_s;
  logic signed [31:0]             t_ax, t_dx;
  logic signed [30:0]             t_ay, t_dy;

  always_ff @(posedge clk) begin
    priority if (div_s[psd_pkg::TFrac].zero) begin
      t_s <= '0;
    end else if (div_s[psd_pkg::TFrac].one) begin
      t_s <= psd_pkg::TOne;
    end else begin
      t_s <= {1'b0, div_s[psd_pkg::TFrac].q};
    end
    t_ax <= div_s[psd_pkg::TFrac].ax;
    t_ay <= div_s[psd_pkg::TFrac].ay;
    t_dx <= div_s[psd_pkg::TFrac].dx;
    t_dy <= div_s[psd_pkg::TFrac].dy;
  end

  // Offset stage: the parameter times each axis of the segment.
  logic signed [57:0] m_tdx;
  logic signed [56:0] m_tdy;
  logic signed [31:0] m_ax;
  logic signed [30:0] m_ay;

  always_ff @(posedge clk) begin
    m_tdx <= $signed({1'b0, t_s}) * t_dx;
    m_tdy <= $signed({1'b0, t_s}) * t_dy;
    m_ax  <= t_ax;
    m_ay  <= t_ay;
  end

  // Residual stage: the arithmetic shift floors the offset. The residual
  // lies between the two end point differences, so its magnitude stays
  // within 2^31.
  logic signed [33:0] res_x, res_y;

  always_ff @(posedge clk) begin
    res_x <= 34'(m_ax) - 34'(m_tdx >>> psd_pkg::TFrac);
    res_y <= 34'(m_ay) - 34'(m_tdy >>> psd_pkg::TFrac);
  end

  // Square stage on the magnitudes.
  logic [31:0] abs_x, abs_y;
  logic [63:0] sq_x, sq_y;

  assign abs_x = res_x[33] ? 32'(-res_x) : res_x[31:0];
  assign abs_y = res_y[33] ? 32'(-res_y) : res_y[31:0];

  always_ff @(posedge clk) begin
    sq_x <= abs_x * abs_x;
    sq_y <= abs_y * abs_y;
  end

  // Sum stage feeds the square root, which takes two radicand bits per stage.
  sqrt_t sqrt_s [psd_pkg::SqrtSteps+1];

  always_ff @(posedge clk) begin
    sqrt_s[0].n    <= sq_x + sq_y;
    sqrt_s[0].rem  <= '0;
    sqrt_s[0].root <= '0;
  end

  for (genvar g = 0; g < psd_pkg::SqrtSteps; g++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    assign rem_sh = {sqrt_s[g].rem, sqrt_s[g].n[63:62]};
    assign trial  = {2'b00, sqrt_s[g].root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      sqrt_s[g+1].n    <= {sqrt_s[g].n[61:0], 2'b00};
      sqrt_s[g+1].rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      sqrt_s[g+1].root <= {sqrt_s[g].root[30:0], ge};
    end
  end

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (sqrt_s[psd_pkg::SqrtSteps].root > 32'(psd_pkg::DistMax)) begin
      distance <= psd_pkg::DistMax;
    end else begin
      distance <= sqrt_s[psd_pkg::SqrtSteps].root[30:0];
    end
  end

  `ASSERT_IMPLIES(a_t_clamped, clk, rst, vld[TStage], t_s <= psd_pkg::TOne)
  `ASSERT_IMPLIES(a_root_floor, clk, rst, vld[OutStage-1],
    {1'b0, sqrt_s[psd_pkg::SqrtSteps].rem} <= {2'b00, sqrt_s[psd_pkg::SqrtSteps].root, 1'b0})
  `ASSERT_IMPLIES(a_done_latency, clk, rst, done, $past(start, psd_pkg::Latency))
  `ASSERT_ALWAYS(a_stage_order, clk, rst, SumStage < OutStage)

endmodule

>>> test/point_segment_distance_checker.sv
module point_segment_distance_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [30:0] point_x,
  input  logic signed [29:0] point_y,
  input  logic signed [30:0] start_x,
  input  logic signed [29:0] start_y,
  input  logic signed [30:0] end_x,
  input  logic signed [29:0] end_y,
  input  logic               done,
  input  logic        [30:0] distance,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [30:0] distance_q[$];

  // Floored square root, one root bit per pass.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Floor division by 2^24.
  function automatic longint floor_frac(longint v);
    return v >>> psd_pkg::TFrac;
  endfunction

  function automatic logic [30:0] segment_distance(
    longint px, longint py, longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, ax, ay, dot, rx, ry;
    logic [63:0] len2, t, rem, sum, d;
    dx = ex - sx;
    dy = ey - sy;
    ax = px - sx;
    ay = py - sy;
    len2 = dx * dx + dy * dy;
    dot = ax * dx + ay * dy;
    if (len2 == 0 || dot <= 0) t = 0;
    else if (64'(dot) >= len2) t = 64'd1 << psd_pkg::TFrac;
    else begin
      rem = dot;
      t = 0;
      for (int i = 0; i < psd_pkg::TFrac; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= len2) begin
          rem = rem - len2;
          t[0] = 1'b1;
        end
      end
    end
    rx = ax - floor_frac(longint'(t) * dx);
    ry = ay - floor_frac(longint'(t) * dy);
    sum = 64'(rx * rx) + 64'(ry * ry);
    d = floor_sqrt(sum);
    if (d > 64'(psd_pkg::DistMax)) d = 64'(psd_pkg::DistMax);
    return d[30:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  assign pending = distance_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst) begin
      if (start && !busy)
        distance_q.push_back(segment_distance(point_x, point_y, start_x, start_y,
                                              end_x, end_y));
      if (done) begin
        if (distance_q.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0d", distance));
        end else begin
          want = distance_q.pop_front();
          if (distance !== want)
            report_mismatch($sformatf("distance %0d, predicted %0d", distance, want));
        end
      end
    end
  end
endmodule

>>> test/point_segment_distance_tb.sv
module point_segment_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int XLim = 754974720;
  localparam int YLim = 377487360;
  localparam int RandomBeats = 830;
  localparam int CycleLimit = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] point_x = '0;
  logic signed [29:0] point_y = '0;
  logic signed [30:0] start_x = '0;
  logic signed [29:0] start_y = '0;
  logic signed [30:0] end_x = '0;
  logic signed [29:0] end_y = '0;
  logic               done;
  logic        [30:0] distance;
  int                 errors;
  int                 pending;
  int                 cycle_count = 0;

  always #5 clk = ~clk;

  point_segment_distance i_dut (.*);

  point_segment_distance_checker i_checker (.*);

  // The cycle counter guards against a block that stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one beat and holds it until the block takes it. The start line is
  // only driven at the rising edge, so it never toggles twice in one step.
  task automatic send_beat(logic signed [30:0] px, logic signed [29:0] py,
                           logic signed [30:0] sx, logic signed [29:0] sy,
                           logic signed [30:0] ex, logic signed [29:0] ey);
    start   <= 1'b1;
    point_x <= px;
    point_y <= py;
    start_x <= sx;
    start_y <= sy;
    end_x   <= ex;
    end_y   <= ey;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // A coordinate either anywhere within its field, across the stated range,
  // or clustered within 1000 of the origin.
  function automatic logic signed [30:0] any_x();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 2 * XLim) - XLim);
      default: return 31'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  function automatic logic signed [29:0] any_y();
    case ($urandom_range(0, 3))
      0: return 30'($urandom);
      1: return 30'($urandom_range(0, 2 * YLim) - YLim);
      default: return 30'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  initial begin
    logic signed [30:0] sx, ex;
    logic signed [29:0] sy, ey;
    bit quiet;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: the range extremes, the full field extremes (where the
    // distance saturates), coincident ends, a point behind the start, a point
    // beyond the end, and a point whose projection falls inside the segment.
    send_beat(0, 0, 0, 0, 0, 0);
    send_beat(XLim, YLim, -XLim, -YLim, -XLim, -YLim);
    send_beat(-XLim, -YLim, XLim, YLim, XLim, YLim);
    send_beat(31'sh3fffffff, 30'sh1fffffff, 31'sh40000000, 30'sh20000000,
              31'sh40000000, 30'sh20000000);
    send_beat(31'sh40000000, 30'sh20000000, 31'sh3fffffff, 30'sh1fffffff,
              31'sh3fffffff, 30'sh1fffffff);
    send_beat(-1000, -500, 0, 0, 1000, 500);
    send_beat(3000, 1200, 0, 0, 1000, 500);
    send_beat(500, 700, 0, 0, 1000, 0);
    send_beat(-XLim, YLim, -XLim, -YLim, XLim, YLim);
    send_beat(XLim, -YLim, -XLim, -YLim, XLim, YLim);
    send_beat(7, -3, 1, 1, 2, 3);
    send_beat(-1, 1, 0, 0, -3, 7);
    send_beat(12345, 0, -XLim, 0, XLim, 0);
    idle_cycle();

    // Hold off until the pipeline has drained completely.
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < RandomBeats; n++) begin
      quiet = (n >= 300 && n < 420);
      sx = any_x();
      sy = any_y();
      ex = $urandom_range(0, 7) == 0 ? sx : any_x();
      ey = $urandom_range(0, 7) == 0 ? sy : any_y();
      send_beat(any_x(), any_y(), sx, sy, ex, ey);
      while (!quiet && $urandom_range(0, 99) < 26) idle_cycle();
    end
    idle_cycle();

    while (pending != 0) @(posedge clk);
    repeat (psd_pkg::Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/psd_pkg.sv
rtl/point_segment_distance.sv
test/point_segment_distance_checker.sv
test/point_segment_distance_tb.sv
